// ===== design/assert_macros.svh =====
// Assertion macros shared by the rational arithmetic unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("lbl failed");
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl failed");
`endif

// ===== design/rau_pkg.sv =====
// Types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned MagWidth = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_NORM = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_DIV_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0] res_den;
    logic [1:0] status;
  } rsp_t;
endpackage

// ===== design/rau_mul.sv =====
// Shared 32x32 magnitude multiplier with registered product.
// Depends on rau_pkg.
module rau_mul import rau_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, x_i} * {32'd0, y_i};
  end
  assign p_o = p_q;
endmodule

// ===== design/rau_gcd.sv =====
// Iterative binary GCD and restoring divider, each with its own 64-bit subtraction logic.
// Depends on rau_pkg.
module rau_gcd import rau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] u_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic [63:0] qu_o,
  output logic [63:0] qv_o
);
  typedef enum logic [2:0] {S_IDLE, S_SH, S_UODD, S_LOOP, S_DIVU, S_DIVV, S_DONE} st_e;
  st_e st_q;
  logic [63:0] u_q, v_q, ou_q, ov_q, g_q, rem_q, quo_q, qu_q;
  logic [63:0] qv_o_q;
  logic [5:0] sh_q, cnt_q;
  logic [64:0] diff;
  logic [64:0] trial;
  logic [63:0] dvd;

  assign diff = {1'b0, v_q} - {1'b0, u_q};
  assign dvd = (st_q == S_DIVU) ? ou_q : ov_q;
  assign trial = {rem_q, dvd[6'd63 - cnt_q]} - {1'b0, g_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      case (st_q)
        S_IDLE: if (start_i) begin
          u_q <= u_i; v_q <= v_i; ou_q <= u_i; ov_q <= v_i; sh_q <= '0;
          st_q <= S_SH;
        end
        S_SH: if (((u_q | v_q) & 64'd1) == 64'd0) begin
          u_q <= u_q >> 1; v_q <= v_q >> 1; sh_q <= sh_q + 6'd1;
        end else st_q <= S_UODD;
        S_UODD: if (!u_q[0]) u_q <= u_q >> 1; else st_q <= S_LOOP;
        S_LOOP: if (v_q == 64'd0) begin
          g_q <= u_q << sh_q;
          cnt_q <= '0; rem_q <= '0; quo_q <= '0;
          st_q <= S_DIVU;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (diff[64]) begin
          v_q <= u_q - v_q; u_q <= v_q;
        end else begin
          v_q <= diff[63:0];
        end
        S_DIVU, S_DIVV: begin
          quo_q <= {quo_q[62:0], ~trial[64]};
          if (cnt_q == 6'd63) begin
            cnt_q <= '0; rem_q <= '0;
            if (st_q == S_DIVU) begin
              qu_q <= {quo_q[62:0], ~trial[64]};
              st_q <= S_DIVV;
            end else begin
              qv_o_q <= {quo_q[62:0], ~trial[64]};
              st_q <= S_DONE;
            end
          end else begin
            cnt_q <= cnt_q + 6'd1;
            if (trial[64]) rem_q <= {rem_q[62:0], dvd[6'd63 - cnt_q]};
            else rem_q <= trial[63:0];
          end
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
  assign done_o = (st_q == S_DONE);
  assign qu_o = qu_q;
  assign qv_o = qv_o_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, st_q == S_DIVU, g_q != 64'd0)
  `ASSERT_IMPL(a_done_one, clk_i, rst_ni, done_o, $past(st_q) == S_DIVV)
  `ASSERT_IMPL(a_loop_uodd, clk_i, rst_ni, st_q == S_LOOP, u_q[0])
endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one word at a time; after acceptance it runs the multiply
// states M0, M1, M2 (and M3 for add and subtract), then the binary GCD loop and two
// 64-step restoring divisions on a shared subtractor. Not ready while busy. Errors go
// straight from idle to the output; zero results skip the GCD. Asynchronous active-low
// reset returns to idle with no result pending.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);
  typedef enum logic [2:0] {IDLE, M0, M1, M2, M3, GCD, OUT} st_e;
  st_e st_q;
  op_e op_q;
  logic signed [63:0] an_q, ad_q, bn_q, bd_q;
  logic [63:0] p0_q, p1_q, nm_q, dm_q;
  logic nn_q, dn_q, n0neg_q, n1neg_q;
  rsp_t rsp_q;
  logic [31:0] mx, my;
  logic [63:0] prod, qu, qv;
  logic gdone, gstart;
  logic [64:0] sum;

  function automatic logic signed [63:0] sx(input logic [31:0] r);
    logic [OPERAND_WIDTH-1:0] t;
    t = r[OPERAND_WIDTH-1:0];
    return 64'(signed'(t));
  endfunction
  function automatic logic [31:0] mg(input logic signed [63:0] x);
    logic [63:0] t;
    t = x[63] ? 64'd0 - 64'(x) : 64'(x);
    return t[31:0];
  endfunction

  op_e rop;
  assign rop = (in_data_i.req_type > 3'd4) ? OP_NORM : op_e'(in_data_i.req_type);

  always_comb begin
    mx = mg(an_q); my = mg(bd_q);
    case (st_q)
      M0: begin
        mx = mg(an_q);
        my = (op_q == OP_MUL) ? mg(bn_q) : (op_q == OP_NORM) ? 32'd1 : mg(bd_q);
      end
      M1: begin
        mx = mg(ad_q);
        my = (op_q == OP_DIV) ? mg(bn_q) : (op_q == OP_NORM) ? 32'd1 : mg(bd_q);
      end
      M2: begin mx = mg(bn_q); my = mg(ad_q); end
      default: ;
    endcase
  end

  rau_mul u_mul (.clk_i(clk_i), .x_i(mx), .y_i(my), .p_o(prod));

  assign gstart = (st_q == GCD);
  rau_gcd u_gcd (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(gstart && !gdone),
    .u_i(nm_q), .v_i(dm_q), .done_o(gdone), .qu_o(qu), .qv_o(qv));

  logic m3neg;
  assign m3neg = (bn_q[63] ^ ad_q[63]) ^ (op_q == OP_SUB);
  assign sum = (n0neg_q == m3neg) ? {1'b0, p0_q} + {1'b0, prod}
             : {1'b0, p0_q} - {1'b0, prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= IDLE;
    end else begin
      case (st_q)
        IDLE: if (in_valid_i) begin
          op_q <= rop;
          an_q <= sx(in_data_i.a_num); ad_q <= sx(in_data_i.a_den);
          bn_q <= sx(in_data_i.b_num); bd_q <= sx(in_data_i.b_den);
          rsp_q.res_num <= '0; rsp_q.res_den <= 63'd1;
          if (sx(in_data_i.a_den) == 0 || (rop != OP_NORM && sx(in_data_i.b_den) == 0)) begin
            rsp_q.status <= ST_ZERO_DEN; st_q <= OUT;
          end else if (rop == OP_DIV && sx(in_data_i.b_num) == 0) begin
            rsp_q.status <= ST_DIV_ZERO; st_q <= OUT;
          end else begin
            rsp_q.status <= ST_OK; st_q <= M0;
          end
        end
        M0: begin
          n0neg_q <= an_q[63] ^ ((op_q == OP_MUL) ? bn_q[63]
                     : (op_q == OP_NORM) ? 1'b0 : bd_q[63]);
          st_q <= M1;
        end
        M1: begin
          p0_q <= prod;
          n1neg_q <= ad_q[63] ^ ((op_q == OP_DIV) ? bn_q[63]
                     : (op_q == OP_NORM) ? 1'b0 : bd_q[63]);
          st_q <= M2;
        end
        M2: begin
          p1_q <= prod;
          if (op_q == OP_ADD || op_q == OP_SUB) st_q <= M3;
          else begin
            nm_q <= p0_q; nn_q <= n0neg_q; dm_q <= prod; dn_q <= n1neg_q;
            if (p0_q == 64'd0) st_q <= OUT; else st_q <= GCD;
          end
        end
        M3: begin
          dm_q <= p1_q; dn_q <= n1neg_q;
          if (sum[64] && n0neg_q != m3neg) begin
            nm_q <= prod - p0_q; nn_q <= m3neg;
          end else begin
            nm_q <= sum[63:0]; nn_q <= n0neg_q;
          end
          if (sum[63:0] == 64'd0) st_q <= OUT; else st_q <= GCD;
        end
        GCD: if (gdone) begin
          rsp_q.res_num <= (nn_q != dn_q) ? 64'd0 - qu : qu;
          rsp_q.res_den <= qv[62:0];
          st_q <= OUT;
        end
        OUT: if (out_ready_i) st_q <= IDLE;
        default: st_q <= IDLE;
      endcase
    end
  end

  assign in_ready_o = (st_q == IDLE);
  assign out_valid_o = (st_q == OUT);
  assign out_data_o = rsp_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_IMPL(a_den_pos, clk_i, rst_ni, out_valid_o, out_data_o.res_den != 63'd0)
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_OK,
    out_data_o.res_num == 64'sd0)
endmodule

// ===== tb/sv/rational_arithmetic_unit_test.sv =====
// Testbench for the rational arithmetic unit: a directed table then random fractions,
// each word checked against its table entry or an exact-arithmetic, binary-GCD predictor.
// Depends on rau_pkg and rational_arithmetic_unit.
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomWords = 1800;

  typedef struct {
    req_t req;
    logic chk;
    rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  rsp_t fraction_q[$];
  row_t dir_rows[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  logic hold_off = 1'b0;
  int unsigned n_fail = 0;
  int unsigned quiet = 0;

  rational_arithmetic_unit dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [63:0] gcd_of(logic [63:0] u, logic [63:0] v);
    int unsigned sh;
    logic [63:0] t;
    sh = 0;
    if (u == 0) return v;
    if (v == 0) return u;
    while (((u | v) & 1) == 0) begin
      u = u >> 1;
      v = v >> 1;
      sh++;
    end
    while ((u & 1) == 0) u = u >> 1;
    while (v != 0) begin
      while ((v & 1) == 0) v = v >> 1;
      if (u > v) begin
        t = u;
        u = v;
        v = t;
      end
      v = v - u;
    end
    return u << sh;
  endfunction

  function automatic rsp_t reduce_fraction(req_t r);
    rsp_t o;
    logic [2:0] op;
    logic signed [63:0] an, ad, bn, bd;
    logic signed [127:0] num, den;
    logic [127:0] nm, dm, g;
    logic neg;
    op = (r.req_type > OP_NORM) ? OP_NORM : r.req_type;
    an = r.a_num;
    ad = r.a_den;
    bn = r.b_num;
    bd = r.b_den;
    o = '{res_num: 64'sd0, res_den: 63'd1, status: ST_OK};
    if (ad == 0 || (op != OP_NORM && bd == 0)) begin
      o.status = ST_ZERO_DEN;
      return o;
    end
    if (op == OP_DIV && bn == 0) begin
      o.status = ST_DIV_ZERO;
      return o;
    end
    case (op)
      OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      OP_MUL: begin num = an * bn; den = ad * bd; end
      OP_DIV: begin num = an * bd; den = ad * bn; end
      default: begin num = an; den = ad; end
    endcase
    if (num == 0) return o;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    g = gcd_of(nm[63:0], dm[63:0]);
    nm = nm / g;
    dm = dm / g;
    o.res_num = neg ? -nm[63:0] : nm[63:0];
    o.res_den = dm[62:0];
    return o;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_word(req_t r, logic chk, rsp_t exp_rsp);
    while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    fraction_q.push_back(chk ? exp_rsp : reduce_fraction(r));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic add_row(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd, logic chk, rsp_t r);
    row_t w;
    w.req = '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    w.chk = chk;
    w.rsp = r;
    dir_rows.push_back(w);
  endtask

  always @(posedge clk_i) begin
    if (!hold_off && (recv_idle == 0 || $urandom_range(0, 99) >= recv_idle))
      out_ready_i <= 1'b1;
    else
      out_ready_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fraction_q.size() == 0) begin
        $error("unexpected word num=%0d den=%0d", out_data_o.res_num, out_data_o.res_den);
        n_fail++;
      end else begin
        rsp_t e;
        e = fraction_q.pop_front();
        if (out_data_o.res_num !== e.res_num) begin
          $error("res_num expected %0d actual %0d", e.res_num, out_data_o.res_num);
          n_fail++;
        end
        if (out_data_o.res_den !== e.res_den) begin
          $error("res_den expected %0d actual %0d", e.res_den, out_data_o.res_den);
          n_fail++;
        end
        if (out_data_o.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data_o.status);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni || hold_off)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rsp_t z1, z2, z0, nz;
    z1 = '{res_num: 64'sd0, res_den: 63'd1, status: ST_ZERO_DEN};
    z2 = '{res_num: 64'sd0, res_den: 63'd1, status: ST_DIV_ZERO};
    z0 = '{res_num: 64'sd0, res_den: 63'd1, status: ST_OK};
    nz = z0;
    add_row(OP_ADD, 1, 0, 1, 1, 1, z1);
    add_row(OP_SUB, 1, 1, 1, 0, 1, z1);
    add_row(OP_DIV, 1, 0, 0, 1, 1, z1);
    add_row(OP_DIV, 5, 3, 0, 7, 1, z2);
    add_row(OP_NORM, 7, 0, 1, 1, 1, z1);
    add_row(OP_NORM, 4, -6, 0, 0, 0, nz);
    add_row(OP_MUL, 0, -9, 5, 2, 1, z0);
    add_row(OP_SUB, 3, 4, 3, 4, 1, z0);
    add_row(OP_ADD, 1, 2, 1, 3, 0, nz);
    add_row(OP_SUB, 1, 2, 1, 3, 0, nz);
    add_row(OP_MUL, -2, 3, 9, -4, 0, nz);
    add_row(OP_DIV, -2, 3, -9, 4, 0, nz);
    add_row(3'd5, -8, -12, 0, 0, 0, nz);
    add_row(3'd6, 32'h8000_0000, -1, 1, 0, 0, nz);
    add_row(3'd7, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, nz);
    add_row(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 0, nz);
    add_row(OP_SUB, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, nz);
    add_row(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 0, nz);
    add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, nz);
    add_row(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, nz);
    add_row(OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, nz);
    add_row(OP_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 0, nz);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) offer_word(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rsp);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 38 : (ph == 1) ? 67 : 0;
      recv_idle = (ph == 0) ? 67 : (ph == 1) ? 38 : 0;
      for (int k = 0; k < RandomWords / 3; k++) begin
        req_t r;
        r.req_type = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
        r.a_num = pick_operand();
        r.a_den = pick_operand();
        r.b_num = pick_operand();
        r.b_den = pick_operand();
        if (ph == 2 && k == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (3000) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        offer_word(r, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (fraction_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_fail == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
